// File: rtl/flcd_pkg.sv
// Shared types and constants for the framed display-text parser.
`timescale 1ns / 1ps
`default_nettype none

package flcd_pkg;

	localparam int COL_WIDTH = 8;
	localparam int NUM_ROWS  = 4;
	localparam int ROW_WIDTH = 3;
	localparam int BYTE_WIDTH = 8;
	localparam int ACC_WIDTH = COL_WIDTH + 4;

	localparam logic [COL_WIDTH-1:0] COL_MAX = {COL_WIDTH{1'b1}};
	localparam logic [ROW_WIDTH-1:0] ROW_FIRST = ROW_WIDTH'(1);
	localparam logic [ROW_WIDTH-1:0] ROW_LAST  = ROW_WIDTH'(NUM_ROWS);

	localparam logic [BYTE_WIDTH-1:0] CH_START = 8'h2A;
	localparam logic [BYTE_WIDTH-1:0] CH_SEP   = 8'h2F;
	localparam logic [BYTE_WIDTH-1:0] CH_ZERO  = 8'h30;
	localparam logic [BYTE_WIDTH-1:0] CH_NINE  = 8'h39;

	typedef enum logic [1:0] {
		PH_WAIT   = 2'd0,
		PH_NUMBER = 2'd1,
		PH_TEXT   = 2'd2
	} phase_t;

	typedef struct packed {
		phase_t                 phase;
		logic [ROW_WIDTH-1:0]   record_row;
		logic [COL_WIDTH-1:0]   position;
	} flcd_state_t;

	typedef struct packed {
		logic                   emit;
		logic [BYTE_WIDTH-1:0]  text_byte;
		logic [ROW_WIDTH-1:0]   row;
		logic [BYTE_WIDTH-1:0]  column;
	} flcd_result_t;

endpackage

`default_nettype wire

// File: rtl/framed_lcd_text_parser_unit.sv
// Top level of the framed display-text parser.
//
// Usage: feed received bytes on rx_byte with in_valid; a byte is taken at a
// clock edge where in_valid is high and in_stall is low. The parser waits
// for a '*' start byte, then reads one record per display row: a decimal
// start column ended by '/', then text ended by '/'. Each text byte yields
// one item on text_byte/row/column with out_valid; the item is taken when
// out_valid is high and out_stall is low.
// Output: an item appears in the cycle after its byte is taken.
// Throughput: one byte per cycle while in_stall is low; the state update and the result both
// fit between the parser state registers and the output register.
// Stall: in_stall rises only while the output register holds an item and
// the receiver stalls; the held item and its fields stay unchanged.
// Reset: arst_n clears the parser to waiting for '*', row one, column zero,
// and empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module framed_lcd_text_parser_unit
	import flcd_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [BYTE_WIDTH-1:0]  rx_byte,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [BYTE_WIDTH-1:0]  text_byte,
	output logic [ROW_WIDTH-1:0]   row,
	output logic [BYTE_WIDTH-1:0]  column
);

	flcd_state_t            state_q;
	flcd_state_t            state_nxt;
	flcd_result_t           res;
	logic                   out_valid_q;
	logic [BYTE_WIDTH-1:0]  text_byte_q;
	logic [ROW_WIDTH-1:0]   row_q;
	logic [BYTE_WIDTH-1:0]  column_q;
	logic                   out_free;
	logic                   take;

	flcd_parse u_parse (
		.cur     (state_q),
		.rx_byte (rx_byte),
		.nxt     (state_nxt),
		.res     (res)
	);

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = !out_free;
	assign take     = in_valid && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase      <= PH_WAIT;
			state_q.record_row <= ROW_FIRST;
			state_q.position   <= '0;
		end else if (take) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= take && res.emit;
		end
	end

	// hold the payload while the receiver stalls
	always_ff @(posedge clk) begin
		if (take && res.emit) begin
			text_byte_q <= res.text_byte;
			row_q       <= res.row;
			column_q    <= res.column;
		end
	end

	assign out_valid = out_valid_q;
	assign text_byte = text_byte_q;
	assign row       = row_q;
	assign column    = column_q;

endmodule

`default_nettype wire

// File: rtl/flcd_parse.sv
// Per-byte parser step: next state and the optional text result.
`timescale 1ns / 1ps
`default_nettype none

module flcd_parse
	import flcd_pkg::*;
(
	input  flcd_state_t            cur,
	input  logic [BYTE_WIDTH-1:0]  rx_byte,
	output flcd_state_t            nxt,
	output flcd_result_t           res
);

	logic                  is_sep;
	logic                  is_digit;
	logic [ACC_WIDTH-1:0]  acc;
	logic [COL_WIDTH-1:0]  acc_sat;
	logic [COL_WIDTH-1:0]  pos_inc;
	logic [ROW_WIDTH-1:0]  row_inc;
	logic                  row_done;

	assign is_sep   = (rx_byte == CH_SEP);
	assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);

	// position * 10 + digit as two shifts and adds
	assign acc = (ACC_WIDTH'(cur.position) << 3) + (ACC_WIDTH'(cur.position) << 1)
		+ ACC_WIDTH'(rx_byte - CH_ZERO);
	assign acc_sat = (acc > ACC_WIDTH'(COL_MAX)) ? COL_MAX : acc[COL_WIDTH-1:0];

	assign pos_inc  = (cur.position < COL_MAX) ? cur.position + 1'b1 : cur.position;
	assign row_inc  = cur.record_row + 1'b1;
	assign row_done = (row_inc > ROW_LAST) || (row_inc == '0);

	// next state
	always_comb begin
		nxt = cur;
		unique case (cur.phase)
			PH_NUMBER: begin
				if (is_sep) begin
					nxt.phase = PH_TEXT;
				end else if (is_digit) begin
					nxt.position = acc_sat;
				end
			end
			PH_TEXT: begin
				if (is_sep) begin
					nxt.position = '0;
					if (row_done) begin
						nxt.record_row = ROW_FIRST;
						nxt.phase      = PH_WAIT;
					end else begin
						nxt.record_row = row_inc;
						nxt.phase      = PH_NUMBER;
					end
				end else begin
					nxt.position = pos_inc;
				end
			end
			default: begin
				// waiting, and the unused code acts as waiting
				if (rx_byte == CH_START) begin
					nxt.phase      = PH_NUMBER;
					nxt.record_row = ROW_FIRST;
					nxt.position   = '0;
				end else begin
					nxt.phase = PH_WAIT;
				end
			end
		endcase
	end

	// result
	always_comb begin
		res.emit      = (cur.phase == PH_TEXT) && !is_sep;
		res.text_byte = rx_byte;
		res.row       = cur.record_row;
		res.column    = BYTE_WIDTH'(cur.position);
	end

endmodule

`default_nettype wire

// File: bench/tb.sv
// Testbench for the framed display-text parser: byte stimulus, prediction and result checks.
`timescale 1ns / 1ps

module tb;
	import flcd_pkg::*;

	localparam int unsigned LIMIT = 400000;
	localparam int unsigned BYTE_TARGET = 2000;
	localparam int unsigned CALM_FROM = 1700;

	typedef struct {
		logic [BYTE_WIDTH-1:0] text;
		logic [ROW_WIDTH-1:0]  row;
		logic [BYTE_WIDTH-1:0] col;
	} glyph_t;

	// Tracks the frame parse and holds the display glyphs still due from the block.
	class lcd_glyph_board;
		phase_t               ph;
		logic [ROW_WIDTH-1:0] cur_row;
		logic [COL_WIDTH-1:0] col_acc;
		glyph_t               glyphs_due [$];
		int unsigned          faults;

		function new();
			ph = PH_WAIT;
			cur_row = ROW_FIRST;
			col_acc = '0;
			faults = 0;
		endfunction

		function int unsigned pending();
			return glyphs_due.size();
		endfunction

		function void take_rx_byte(logic [BYTE_WIDTH-1:0] b);
			int unsigned acc;
			glyph_t g;
			case (ph)
				PH_NUMBER: begin
					if (b == CH_SEP) begin
						ph = PH_TEXT;
					end else if (b >= CH_ZERO && b <= CH_NINE) begin
						acc = int'(col_acc) * 10 + int'(b) - int'(CH_ZERO);
						col_acc = (acc > int'(COL_MAX)) ? COL_MAX : COL_WIDTH'(acc);
					end
				end
				PH_TEXT: begin
					if (b == CH_SEP) begin
						// next record; the row counter wraps at its own width
						cur_row = cur_row + 1'b1;
						col_acc = '0;
						if (cur_row > ROW_LAST || cur_row == '0) begin
							cur_row = ROW_FIRST;
							ph = PH_WAIT;
						end else begin
							ph = PH_NUMBER;
						end
					end else begin
						g.text = b;
						g.row = cur_row;
						g.col = BYTE_WIDTH'(col_acc);
						glyphs_due.push_back(g);
						if (col_acc != COL_MAX)
							col_acc = col_acc + 1'b1;
					end
				end
				default: begin
					// the unused phase code behaves as waiting
					if (b == CH_START) begin
						ph = PH_NUMBER;
						cur_row = ROW_FIRST;
						col_acc = '0;
					end else begin
						ph = PH_WAIT;
					end
				end
			endcase
		endfunction

		function void match_glyph(logic [BYTE_WIDTH-1:0] t, logic [ROW_WIDTH-1:0] r,
				logic [BYTE_WIDTH-1:0] c);
			glyph_t g;
			if (glyphs_due.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("%0t: unexpected item text_byte=%h row=%0d column=%0d",
						$time, t, r, c);
				return;
			end
			g = glyphs_due.pop_front();
			if (t !== g.text || r !== g.row || c !== g.col) begin
				faults++;
				if (faults <= 10)
					$display("%0t: mismatch expected text_byte=%h row=%0d column=%0d, got %h %0d %0d",
						$time, g.text, g.row, g.col, t, r, c);
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [BYTE_WIDTH-1:0] rx_byte = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [BYTE_WIDTH-1:0] text_byte;
	logic [ROW_WIDTH-1:0]  row;
	logic [BYTE_WIDTH-1:0] column;

	lcd_glyph_board board;
	bit                    idle_on = 1'b1;
	int unsigned           sent = 0;
	int unsigned           cycles = 0;

	framed_lcd_text_parser_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.rx_byte   (rx_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.text_byte (text_byte),
		.row       (row),
		.column    (column)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				board.match_glyph(text_byte, row, column);
			if (in_valid && !in_stall)
				board.take_rx_byte(rx_byte);
		end
	end

	// Receiver stalls in bursts while idling is on.
	initial begin
		forever begin
			@(negedge clk);
			if (idle_on && $urandom_range(0, 6) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 11)) @(negedge clk);
			end
			out_stall <= 1'b0;
		end
	end

	task automatic send_byte(input logic [BYTE_WIDTH-1:0] b);
		@(negedge clk);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (in_stall);
		sent++;
	endtask

	// Drop valid so the last byte is not taken again, then wait for every due item.
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
	endtask

	initial begin
		logic [BYTE_WIDTH-1:0] opening [26];
		logic [BYTE_WIDTH-1:0] nb;
		int unsigned digits, len, cut;
		bit paused;

		board = new();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Noise while waiting, saturation of number and column, star as text,
		// non-digits and an empty number, then an empty last record.
		opening = '{8'h00, 8'hFF, 8'h78, CH_START, 8'h32, 8'h35, 8'h34, CH_SEP,
			8'h00, 8'hFF, CH_START, CH_SEP,
			8'h3A, CH_START, CH_SEP, 8'h5A, CH_SEP,
			8'h39, 8'h39, 8'h39, CH_SEP, 8'h71, 8'h72, CH_SEP,
			CH_SEP, CH_SEP};
		foreach (opening[i])
			send_byte(opening[i]);
		wait_drained();

		paused = 1'b0;
		while (sent < BYTE_TARGET) begin
			idle_on = (sent < CALM_FROM) && ($urandom_range(0, 3) != 0);
			if (!paused && sent > BYTE_TARGET / 2) begin
				wait_drained();
				paused = 1'b1;
			end
			// stray bytes between frames
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 4)) send_byte(BYTE_WIDTH'($urandom_range(0, 255)));
			cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, NUM_ROWS - 1) : NUM_ROWS;
			send_byte(CH_START);
			for (int r = 0; r < NUM_ROWS; r++) begin
				if (r == cut)
					break;
				digits = $urandom_range(0, 3);
				for (int k = 0; k < digits; k++) begin
					if ($urandom_range(0, 7) == 0) begin
						nb = BYTE_WIDTH'($urandom_range(0, 255));
						if ((nb >= CH_ZERO && nb <= CH_NINE) || nb == CH_SEP)
							nb = CH_START;
						send_byte(nb);
					end
					send_byte(CH_ZERO + BYTE_WIDTH'($urandom_range(0, 9)));
				end
				send_byte(CH_SEP);
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 7);
				for (int k = 0; k < len; k++) begin
					nb = BYTE_WIDTH'($urandom_range(0, 255));
					if (nb == CH_SEP)
						nb = 8'h2E;
					send_byte(nb);
				end
				send_byte(CH_SEP);
			end
		end

		wait_drained();
		repeat (4) @(posedge clk);
		if (board.faults == 0 && board.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
